/* hdl/pl0_pkg.sv */
`timescale 1ns / 1ps
// Shared codes for the P-machine core: modes, opcodes, OPR/SYS subcodes,
// run status, clamp limits and the sequencer state type. No dependencies.
package pl0_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam int OP_LIT = 1;
  localparam int OP_OPR = 2;
  localparam int OP_LOD = 3;
  localparam int OP_STO = 4;
  localparam int OP_CAL = 5;
  localparam int OP_INC = 6;
  localparam int OP_JMP = 7;
  localparam int OP_JPC = 8;
  localparam int OP_SYS = 9;

  localparam int OPR_RTN = 0;
  localparam int OPR_NEG = 1;
  localparam int OPR_ADD = 2;
  localparam int OPR_SUB = 3;
  localparam int OPR_MUL = 4;
  localparam int OPR_DIV = 5;
  localparam int OPR_ODD = 6;
  localparam int OPR_MOD = 7;
  localparam int OPR_EQL = 8;
  localparam int OPR_NEQ = 9;
  localparam int OPR_LSS = 10;
  localparam int OPR_LEQ = 11;
  localparam int OPR_GTR = 12;
  localparam int OPR_GEQ = 13;

  localparam int SYS_WRITE = 1;
  localparam int SYS_READ  = 2;
  localparam int SYS_HALT  = 3;

  // program length register width; level and operand words clamp to +-2^40
  localparam int PL_BITS    = 9;
  localparam int CLAMP_BITS = 42;
  localparam logic signed [63:0] CLAMP_LIM = 64'sd1 <<< 40;

  typedef enum logic [13:0] {
    S_CLEAR = 14'h0001,
    S_IDLE  = 14'h0002,
    S_F0    = 14'h0004,
    S_F1    = 14'h0008,
    S_F2    = 14'h0010,
    S_F3    = 14'h0020,
    S_WALK  = 14'h0040,
    S_WALKW = 14'h0080,
    S_RA    = 14'h0100,
    S_RB    = 14'h0200,
    S_RC    = 14'h0400,
    S_ARITH = 14'h0800,
    S_EXEC  = 14'h1000,
    S_WR    = 14'h2000
  } state_t;

endpackage

/* hdl/pl0_stack_machine_core.sv */
`timescale 1ns / 1ps
// P-machine core: sequencer around one single-port word memory holding code and data.
// Depends on pl0_pkg.
//
// Usage: after reset the core sweeps the word memory to zero, one word per cycle,
// with busy high. Load and start items, and steps while halted, are answered in the
// cycle after they are taken. A step fetches opcode, level and operand (F0 to F3);
// CAL, and LOD or STO inside a procedure, then follow one static link per memory read;
// then the operands are read (up to 2), MUL, DIV and MOD run a bit-serial loop, the
// step executes, and then does its memory writes (up to 3). A fault ends a step early.
// Step length is set by the one memory port, which does one read or one write a cycle.
// Each result shows for one cycle with out_strobe; the receiver cannot stall it.
module pl0_stack_machine_core #(
  parameter int MEM_WORDS = 512,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [8:0]         in_load_address,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_read_value,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [8:0]         out_prog_counter,
  output logic [8:0]         out_base_pointer,
  output logic [9:0]         out_stack_pointer,
  output logic signed [9:0]  out_data_pointer,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic               out_read_taken
);
  import pl0_pkg::*;

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int BW  = (AW > PL_BITS) ? AW : PL_BITS;
  localparam int W   = WORD_BITS;
  localparam int CW  = CLAMP_BITS;
  localparam int XW  = (W > CW) ? W : CW;
  localparam int AXW = CW + 2;
  localparam int CTW = $clog2(WORD_BITS + 1);

  localparam logic signed [XW-1:0]  BIG_X   = XW'(CLAMP_LIM);
  localparam logic signed [CW-1:0]  BIG_C   = CW'(CLAMP_LIM);
  localparam logic signed [AXW-1:0] ZERO_X  = '0;
  localparam logic signed [AXW-1:0] ONE_X   = AXW'(1);
  localparam logic signed [AXW-1:0] TWO_X   = AXW'(2);
  localparam logic signed [AXW-1:0] THREE_X = AXW'(3);
  localparam logic signed [AXW-1:0] NEG1_X  = AXW'(-1);
  localparam logic signed [AXW-1:0] MEM_X   = AXW'(MEM_WORDS);

  function automatic logic signed [CW-1:0] clampw(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > BIG_X) clampw = BIG_C;
    else if (e < -BIG_X) clampw = -BIG_C;
    else clampw = CW'(e);
  endfunction

  function automatic logic in_mem(input logic signed [AXW-1:0] a);
    in_mem = (a >= ZERO_X) && (a < MEM_X);
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
    absw = v[W-1] ? -v : v;
  endfunction

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PL_BITS-1:0] pl_r, pl_nxt;
  logic [AW-1:0] pc_r, pc_nxt;
  logic [BW-1:0] bp_r, bp_nxt;
  logic [AW:0] sp_r, sp_nxt;
  logic signed [BW:0] dp_r, dp_nxt;
  logic [1:0] status_r, status_nxt;
  logic signed [W-1:0] op_r, op_nxt, a_r, a_nxt, b_r, b_nxt, rv_r, rv_nxt;
  logic signed [CW-1:0] lv_r, lv_nxt, m_r, m_nxt, arb_r, arb_nxt;
  logic [AW:0] lc_r, lc_nxt;
  logic [W:0] acc_r, acc_nxt;
  logic [W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [CTW-1:0] ac_r, ac_nxt;
  logic [AW-1:0] wa_r [3];
  logic [AW-1:0] wa_nxt [3];
  logic [W-1:0] wv_r [3];
  logic [W-1:0] wv_nxt [3];
  logic [1:0] wn_r, wn_nxt, widx_r, widx_nxt;
  logic strobe_r, strobe_nxt, ov_r, ov_nxt, taken_r, taken_nxt;
  logic signed [31:0] oval_r, oval_nxt;

  // word memory
  logic [W-1:0] mem [MEM_WORDS];
  logic signed [W-1:0] rdata_r;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  // widened views of the machine registers
  logic signed [AXW-1:0] pc_x, bp_x, sp_x, dp_x, pl_x, m_x, lv_x, arb_x, la_x;
  logic signed [AXW-1:0] top_x, sec_x, push_x, laddr_x;
  logic main_lvl;

  assign pc_x  = AXW'(pc_r);
  assign bp_x  = AXW'(bp_r);
  assign sp_x  = AXW'(sp_r);
  assign dp_x  = AXW'(dp_r);
  assign pl_x  = AXW'(pl_r);
  assign m_x   = AXW'(m_r);
  assign lv_x  = AXW'(lv_r);
  assign arb_x = AXW'(arb_r);
  assign la_x  = AXW'(in_load_address);
  assign main_lvl = (bp_x == pl_x);
  assign top_x  = main_lvl ? dp_x : sp_x;
  assign sec_x  = main_lvl ? dp_x - ONE_X : sp_x + ONE_X;
  assign push_x = main_lvl ? dp_x + ONE_X : sp_x - ONE_X;
  assign laddr_x = main_lvl ? pl_x + m_x :
                   ((arb_x == pl_x) ? arb_x + m_x : arb_x - m_x);

  // operand read plan
  logic need1, need2;
  logic signed [AXW-1:0] ra1_x, ra2_x;

  always_comb begin
    need1 = 1'b0;
    need2 = 1'b0;
    ra1_x = top_x;
    ra2_x = top_x;
    case (op_r)
      OP_OPR: begin
        if (m_r == OPR_RTN) begin
          need1 = 1'b1;
          need2 = 1'b1;
          ra1_x = bp_x - ONE_X;
          ra2_x = bp_x - TWO_X;
        end else if (m_r == OPR_NEG || m_r == OPR_ODD) begin
          need1 = 1'b1;
        end else if (m_r inside {[OPR_ADD:OPR_GEQ]}) begin
          need1 = 1'b1;
          need2 = 1'b1;
          ra1_x = sec_x;
        end
      end
      OP_LOD: begin
        need1 = 1'b1;
        ra1_x = laddr_x;
      end
      OP_STO, OP_JPC: need1 = 1'b1;
      OP_SYS: need1 = (m_r == SYS_WRITE);
      default: ;
    endcase
  end

  // execute: next registers, pending writes and fault check
  logic signed [AXW-1:0] ex_npc, ex_nbp, ex_nsp, ex_ndp;
  logic signed [AXW-1:0] ex_wa [3];
  logic [W-1:0] ex_wv [3];
  logic [1:0] ex_wn;
  logic ex_halt, ex_ov, ex_taken, ex_fault;
  logic signed [31:0] ex_oval;

  always_comb begin
    logic [W-1:0] res;
    res = '0;
    ex_npc = pc_x + THREE_X;
    ex_nbp = bp_x;
    ex_nsp = sp_x;
    ex_ndp = dp_x;
    for (int i = 0; i < 3; i++) begin
      ex_wa[i] = ZERO_X;
      ex_wv[i] = '0;
    end
    ex_wn = 2'd0;
    ex_halt = 1'b0;
    ex_ov = 1'b0;
    ex_oval = '0;
    ex_taken = 1'b0;
    ex_fault = 1'b0;
    case (op_r)
      OP_LIT: begin
        if (main_lvl) ex_ndp = dp_x + ONE_X; else ex_nsp = sp_x - ONE_X;
        ex_wa[0] = push_x;
        ex_wv[0] = W'(m_r);
        ex_wn = 2'd1;
      end
      OP_OPR: begin
        if (m_r == OPR_RTN) begin
          ex_nsp = bp_x + ONE_X;
          ex_nbp = AXW'(clampw(a_r));
          ex_npc = AXW'(clampw(b_r));
        end else if (m_r == OPR_NEG) begin
          ex_wa[0] = top_x;
          ex_wv[0] = -a_r;
          ex_wn = 2'd1;
        end else if (m_r == OPR_ODD) begin
          ex_wa[0] = top_x;
          ex_wv[0] = a_r[0] ? (a_r[W-1] ? '1 : W'(1)) : '0;
          ex_wn = 2'd1;
        end else if (m_r inside {[OPR_ADD:OPR_GEQ]}) begin
          case (m_r)
            OPR_ADD: res = a_r + b_r;
            OPR_SUB: res = a_r - b_r;
            OPR_MUL: res = acc_r[W-1:0];
            OPR_DIV: res = (a_r[W-1] ^ b_r[W-1]) ? -my_r : my_r;
            OPR_MOD: res = a_r[W-1] ? -acc_r[W-1:0] : acc_r[W-1:0];
            OPR_EQL: res = W'(a_r == b_r);
            OPR_NEQ: res = W'(a_r != b_r);
            OPR_LSS: res = W'(a_r < b_r);
            OPR_LEQ: res = W'(a_r <= b_r);
            OPR_GTR: res = W'(a_r > b_r);
            default: res = W'(a_r >= b_r);
          endcase
          if ((m_r == OPR_DIV || m_r == OPR_MOD) && b_r == '0) ex_fault = 1'b1;
          ex_wa[0] = sec_x;
          ex_wv[0] = res;
          ex_wn = 2'd1;
          if (main_lvl) ex_ndp = dp_x - ONE_X; else ex_nsp = sp_x + ONE_X;
        end else begin
          ex_fault = 1'b1;
        end
      end
      OP_LOD: begin
        if (main_lvl) ex_ndp = dp_x + ONE_X; else ex_nsp = sp_x - ONE_X;
        ex_wa[0] = push_x;
        ex_wv[0] = a_r;
        ex_wn = 2'd1;
      end
      OP_STO: begin
        ex_wa[0] = laddr_x;
        ex_wv[0] = a_r;
        ex_wn = 2'd1;
        if (main_lvl) ex_ndp = dp_x - ONE_X; else ex_nsp = sp_x + ONE_X;
      end
      OP_CAL: begin
        ex_wa[0] = sp_x - ONE_X;
        ex_wv[0] = W'(arb_r);
        ex_wa[1] = sp_x - TWO_X;
        ex_wv[1] = W'(bp_x);
        ex_wa[2] = sp_x - THREE_X;
        ex_wv[2] = W'(pc_x + THREE_X);
        ex_wn = 2'd3;
        ex_nbp = sp_x - ONE_X;
        ex_npc = m_x;
      end
      OP_INC: begin
        if (main_lvl) ex_ndp = dp_x + m_x; else ex_nsp = sp_x - m_x;
      end
      OP_JMP: ex_npc = m_x;
      OP_JPC: begin
        if (a_r == '0) ex_npc = m_x;
        if (main_lvl) ex_ndp = dp_x - ONE_X; else ex_nsp = sp_x + ONE_X;
      end
      OP_SYS: begin
        if (m_r == SYS_WRITE) begin
          ex_ov = 1'b1;
          ex_oval = 32'(a_r);
          if (main_lvl) ex_ndp = dp_x - ONE_X; else ex_nsp = sp_x + ONE_X;
        end else if (m_r == SYS_READ) begin
          if (main_lvl) ex_ndp = dp_x + ONE_X; else ex_nsp = sp_x - ONE_X;
          ex_wa[0] = push_x;
          ex_wv[0] = rv_r;
          ex_wn = 2'd1;
          ex_taken = 1'b1;
        end else if (m_r == SYS_HALT) begin
          ex_halt = 1'b1;
        end
      end
      default: ex_fault = 1'b1;
    endcase
    for (int i = 0; i < 3; i++) begin
      if (i < int'(ex_wn) && !in_mem(ex_wa[i])) ex_fault = 1'b1;
    end
    if (!in_mem(ex_npc) || !in_mem(ex_nbp)) ex_fault = 1'b1;
    if (ex_nsp < ZERO_X || ex_nsp > MEM_X) ex_fault = 1'b1;
    if (ex_ndp < NEG1_X || ex_ndp >= MEM_X) ex_fault = 1'b1;
  end

  assign busy = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    logic go_fault;
    logic need_walk;
    logic [W:0] sh;
    go_fault = 1'b0;
    need_walk = 1'b0;
    sh = '0;
    state_nxt = state_r;
    clr_nxt = clr_r;
    pl_nxt = cfg_wr_en ? cfg_wr_data : pl_r;
    pc_nxt = pc_r;
    bp_nxt = bp_r;
    sp_nxt = sp_r;
    dp_nxt = dp_r;
    status_nxt = status_r;
    op_nxt = op_r;
    lv_nxt = lv_r;
    m_nxt = m_r;
    a_nxt = a_r;
    b_nxt = b_r;
    rv_nxt = rv_r;
    arb_nxt = arb_r;
    lc_nxt = lc_r;
    acc_nxt = acc_r;
    mx_nxt = mx_r;
    my_nxt = my_r;
    ac_nxt = ac_r;
    for (int i = 0; i < 3; i++) begin
      wa_nxt[i] = wa_r[i];
      wv_nxt[i] = wv_r[i];
    end
    wn_nxt = wn_r;
    widx_nxt = widx_r;
    strobe_nxt = 1'b0;
    ov_nxt = ov_r;
    oval_nxt = oval_r;
    taken_nxt = taken_r;
    mem_we = 1'b0;
    mem_wa = wa_r[widx_r];
    mem_wd = wv_r[widx_r];
    mem_ra = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ov_nxt = 1'b0;
          oval_nxt = '0;
          taken_nxt = 1'b0;
          rv_nxt = W'(in_read_value);
          case (in_mode)
            MODE_LOAD: begin
              if (la_x < MEM_X) begin
                mem_we = 1'b1;
                mem_wa = AW'(in_load_address);
                mem_wd = W'(in_load_value);
              end
              strobe_nxt = 1'b1;
            end
            MODE_START: begin
              pc_nxt = '0;
              bp_nxt = BW'(pl_r);
              dp_nxt = (BW+1)'(pl_x - ONE_X);
              sp_nxt = (AW+1)'(MEM_WORDS);
              status_nxt = ST_RUN;
              strobe_nxt = 1'b1;
            end
            MODE_STEP: begin
              if (status_r == ST_RUN) state_nxt = S_F0;
              else strobe_nxt = 1'b1;
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_F0: begin
        mem_ra = pc_r;
        state_nxt = S_F1;
      end
      S_F1: begin
        op_nxt = rdata_r;
        if (in_mem(pc_x + ONE_X)) begin
          mem_ra = AW'(pc_x + ONE_X);
          state_nxt = S_F2;
        end else go_fault = 1'b1;
      end
      S_F2: begin
        lv_nxt = clampw(rdata_r);
        if (in_mem(pc_x + TWO_X)) begin
          mem_ra = AW'(pc_x + TWO_X);
          state_nxt = S_F3;
        end else go_fault = 1'b1;
      end
      S_F3: begin
        m_nxt = clampw(rdata_r);
        arb_nxt = CW'(bp_x);
        lc_nxt = (lv_x > ZERO_X) ? lv_x[AW:0] : '0;
        need_walk = (op_r == OP_CAL) ||
                    (!main_lvl && (op_r == OP_LOD || op_r == OP_STO));
        if (need_walk && lv_x > MEM_X) go_fault = 1'b1;
        else state_nxt = need_walk ? S_WALK : S_RA;
      end
      S_WALK: begin
        if (lc_r == '0) state_nxt = S_RA;
        else if (in_mem(arb_x)) begin
          mem_ra = AW'(arb_x);
          state_nxt = S_WALKW;
        end else go_fault = 1'b1;
      end
      S_WALKW: begin
        // follow one static link
        arb_nxt = clampw(rdata_r);
        lc_nxt = lc_r - 1'b1;
        state_nxt = S_WALK;
      end
      S_RA: begin
        if (!need1) state_nxt = S_EXEC;
        else if (in_mem(ra1_x)) begin
          mem_ra = AW'(ra1_x);
          state_nxt = S_RB;
        end else go_fault = 1'b1;
      end
      S_RB: begin
        a_nxt = rdata_r;
        if (!need2) state_nxt = S_EXEC;
        else if (in_mem(ra2_x)) begin
          mem_ra = AW'(ra2_x);
          state_nxt = S_RC;
        end else go_fault = 1'b1;
      end
      S_RC: begin
        b_nxt = rdata_r;
        state_nxt = S_EXEC;
        if (m_r == OPR_MUL || m_r == OPR_DIV || m_r == OPR_MOD) begin
          acc_nxt = '0;
          ac_nxt = CTW'(WORD_BITS);
          if (m_r == OPR_MUL) begin
            mx_nxt = a_r;
            my_nxt = rdata_r;
          end else begin
            mx_nxt = absw(rdata_r);
            my_nxt = absw(a_r);
          end
          state_nxt = S_ARITH;
        end
      end
      S_ARITH: begin
        if (ac_r == '0) state_nxt = S_EXEC;
        else begin
          ac_nxt = ac_r - 1'b1;
          if (m_r == OPR_MUL) begin
            if (my_r[0]) acc_nxt = acc_r + {1'b0, mx_r};
            mx_nxt = mx_r << 1;
            my_nxt = my_r >> 1;
          end else begin
            // restoring divide: quotient shifts into my, remainder in acc
            sh = {acc_r[W-1:0], my_r[W-1]};
            if (sh >= {1'b0, mx_r}) begin
              acc_nxt = sh - {1'b0, mx_r};
              my_nxt = {my_r[W-2:0], 1'b1};
            end else begin
              acc_nxt = sh;
              my_nxt = {my_r[W-2:0], 1'b0};
            end
          end
        end
      end
      S_EXEC: begin
        if (ex_fault) go_fault = 1'b1;
        else begin
          pc_nxt = AW'(ex_npc);
          bp_nxt = BW'(ex_nbp);
          sp_nxt = (AW+1)'(ex_nsp);
          dp_nxt = (BW+1)'(ex_ndp);
          if (ex_halt) status_nxt = ST_HALT;
          ov_nxt = ex_ov;
          oval_nxt = ex_oval;
          taken_nxt = ex_taken;
          for (int i = 0; i < 3; i++) begin
            wa_nxt[i] = AW'(ex_wa[i]);
            wv_nxt[i] = ex_wv[i];
          end
          wn_nxt = ex_wn;
          widx_nxt = '0;
          if (ex_wn == 2'd0) begin
            strobe_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else state_nxt = S_WR;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        widx_nxt = widx_r + 1'b1;
        if (widx_r == wn_r - 2'd1) begin
          strobe_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // drop the instruction: nothing but status changes
    if (go_fault) begin
      status_nxt = ST_ERR;
      strobe_nxt = 1'b1;
      ov_nxt = 1'b0;
      oval_nxt = '0;
      taken_nxt = 1'b0;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      pl_r <= '0;
      pc_r <= '0;
      bp_r <= '0;
      sp_r <= (AW+1)'(MEM_WORDS);
      dp_r <= '1;
      status_r <= ST_RUN;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      pl_r <= pl_nxt;
      pc_r <= pc_nxt;
      bp_r <= bp_nxt;
      sp_r <= sp_nxt;
      dp_r <= dp_nxt;
      status_r <= status_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    lv_r <= lv_nxt;
    m_r <= m_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    rv_r <= rv_nxt;
    arb_r <= arb_nxt;
    lc_r <= lc_nxt;
    acc_r <= acc_nxt;
    mx_r <= mx_nxt;
    my_r <= my_nxt;
    ac_r <= ac_nxt;
    for (int i = 0; i < 3; i++) begin
      wa_r[i] <= wa_nxt[i];
      wv_r[i] <= wv_nxt[i];
    end
    wn_r <= wn_nxt;
    widx_r <= widx_nxt;
    ov_r <= ov_nxt;
    oval_r <= oval_nxt;
    taken_r <= taken_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_prog_counter  = 9'(pc_r);
  assign out_base_pointer  = 9'(bp_r);
  assign out_stack_pointer = 10'(sp_r);
  assign out_data_pointer  = 10'(dp_r);
  assign out_out_valid     = ov_r;
  assign out_out_value     = oval_r;
  assign out_read_taken    = taken_r;

  a_halted_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_STEP && status_r != ST_RUN)
      |=> (strobe_r && $stable(pc_r) && $stable(sp_r) && $stable(dp_r)))
    else $error("step while halted changed machine state");

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_START)
      |=> (strobe_r && pc_r == '0 && status_r == ST_RUN))
    else $error("start item did not initialize the machine");

  a_io_running: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && (ov_r || taken_r)) |-> (status_r == ST_RUN))
    else $error("I/O reported on a faulted or halted step");

  a_mem_writer: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_IDLE || state_r == S_WR))
    else $error("memory written outside clear, load or commit");

  a_fault_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && ex_fault) |=> (status_r == ST_ERR && !ov_r && state_r == S_IDLE))
    else $error("faulting instruction did not end in error status");

endmodule

/* sim/pl0_stack_machine_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for pl0_stack_machine_core: loads small P-machine programs,
// runs them step by step and checks every result against a built-in predictor.
// Depends on pl0_pkg and the core RTL.
module pl0_stack_machine_core_tb;
  import pl0_pkg::*;

  typedef struct {
    bit [1:0]  status;
    bit [8:0]  pc;
    bit [8:0]  bp;
    bit [9:0]  sp;
    bit [9:0]  dp;
    bit        wvalid;
    bit [31:0] wvalue;
    bit        taken;
  } vm_view_t;

  class pl0_scoreboard;
    bit [31:0] mem [512];
    longint pc, bp, sp, dp;
    bit [1:0] status;
    bit [8:0] plen;
    vm_view_t expected_views [$];
    int errors, checked, writes, halts, faults;
    bit flt;
    int np;
    longint pa [4];
    bit [31:0] pv [4];

    function new();
      foreach (mem[i]) mem[i] = '0;
      pc = 0; bp = 0; sp = 512; dp = -1; status = ST_RUN; plen = 0;
    endfunction

    function longint rd(longint a);
      if (a < 0 || a >= 512) begin
        flt = 1;
        return 0;
      end
      return longint'($signed(mem[a]));
    endfunction

    function void wr(longint a, longint v);
      if (a < 0 || a >= 512 || np >= 4) begin
        flt = 1;
        return;
      end
      pa[np] = a;
      pv[np] = v[31:0];
      np++;
    endfunction

    function longint link_base(longint lv);
      longint arb;
      arb = bp;
      if (lv > 512) begin
        flt = 1;
        return 0;
      end
      while (lv > 0 && !flt) begin
        arb = rd(arb);
        lv--;
      end
      return arb;
    endfunction

    // one instruction; registers and memory change only if no fault
    function void exec_instr(longint rv, ref vm_view_t v);
      longint op, lv, m, npc, nbp, nsp, ndp, top, sec, x, y, b, res;
      bit main_lvl, halt;
      flt = 0; np = 0; halt = 0; res = 0;
      op = rd(pc);
      lv = rd(pc + 1);
      m = rd(pc + 2);
      npc = pc + 3; nbp = bp; nsp = sp; ndp = dp;
      main_lvl = (bp == longint'(plen));
      top = main_lvl ? dp : sp;
      sec = main_lvl ? dp - 1 : sp + 1;
      if (!flt) begin
        case (op)
          OP_LIT: if (main_lvl) begin ndp++; wr(ndp, m); end
                  else begin nsp--; wr(nsp, m); end
          OP_OPR: begin
            if (m == OPR_RTN) begin
              nsp = bp + 1;
              nbp = rd(bp - 1);
              npc = rd(bp - 2);
            end else if (m == OPR_NEG) begin
              wr(top, -rd(top));
            end else if (m == OPR_ODD) begin
              wr(top, rd(top) % 2);
            end else if (m >= OPR_ADD && m <= OPR_GEQ) begin
              x = rd(sec);
              y = rd(top);
              case (m)
                OPR_ADD: res = x + y;
                OPR_SUB: res = x - y;
                OPR_MUL: res = x * y;
                OPR_DIV, OPR_MOD: begin
                  if (y == 0) flt = 1;
                  else if (y == -1) res = (m == OPR_DIV) ? -x : 0;
                  else res = (m == OPR_DIV) ? x / y : x % y;
                end
                OPR_EQL: res = (x == y);
                OPR_NEQ: res = (x != y);
                OPR_LSS: res = (x < y);
                OPR_LEQ: res = (x <= y);
                OPR_GTR: res = (x > y);
                default: res = (x >= y);
              endcase
              wr(sec, res);
              if (main_lvl) ndp--; else nsp++;
            end else begin
              flt = 1;
            end
          end
          OP_LOD: begin
            if (main_lvl) begin
              x = rd(longint'(plen) + m);
              ndp++;
              wr(ndp, x);
            end else begin
              b = link_base(lv);
              x = rd(b == longint'(plen) ? b + m : b - m);
              nsp--;
              wr(nsp, x);
            end
          end
          OP_STO: begin
            if (main_lvl) begin
              wr(longint'(plen) + m, rd(dp));
              ndp--;
            end else begin
              b = link_base(lv);
              wr(b == longint'(plen) ? b + m : b - m, rd(sp));
              nsp++;
            end
          end
          OP_CAL: begin
            b = link_base(lv);
            wr(sp - 1, b);
            wr(sp - 2, bp);
            wr(sp - 3, npc);
            nbp = sp - 1;
            npc = m;
          end
          OP_INC: if (main_lvl) ndp += m; else nsp -= m;
          OP_JMP: npc = m;
          OP_JPC: begin
            if (rd(top) == 0) npc = m;
            if (main_lvl) ndp--; else nsp++;
          end
          OP_SYS: begin
            if (m == SYS_WRITE) begin
              x = rd(top);
              v.wvalue = x[31:0];
              v.wvalid = 1;
              if (main_lvl) ndp--; else nsp++;
            end else if (m == SYS_READ) begin
              if (main_lvl) begin ndp++; wr(ndp, rv); end
              else begin nsp--; wr(nsp, rv); end
              v.taken = 1;
            end else if (m == SYS_HALT) begin
              halt = 1;
            end
          end
          default: flt = 1;
        endcase
      end
      if (npc < 0 || npc >= 512 || nbp < 0 || nbp >= 512 ||
          nsp < 0 || nsp > 512 || ndp < -1 || ndp >= 512)
        flt = 1;
      if (flt) begin
        status = ST_ERR;
        v.wvalid = 0; v.wvalue = 0; v.taken = 0;
        faults++;
        return;
      end
      for (int i = 0; i < np; i++) mem[pa[i]] = pv[i];
      pc = npc; bp = nbp; sp = nsp; dp = ndp;
      if (halt) begin
        status = ST_HALT;
        halts++;
      end
    endfunction

    function void note_item(bit [1:0] mode, bit [8:0] addr, int lval, int rval);
      vm_view_t v;
      v = '{default: '0};
      if (mode == MODE_LOAD) begin
        mem[addr] = lval;
      end else if (mode == MODE_START) begin
        pc = 0; bp = plen; dp = longint'(plen) - 1; sp = 512; status = ST_RUN;
      end else if (mode == MODE_STEP && status == ST_RUN) begin
        exec_instr(longint'(rval), v);
      end
      if (v.wvalid) writes++;
      v.status = status;
      v.pc = pc[8:0];
      v.bp = bp[8:0];
      v.sp = sp[9:0];
      v.dp = dp[9:0];
      expected_views.push_back(v);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(vm_view_t got);
      vm_view_t e;
      if (expected_views.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = expected_views.pop_front();
      checked++;
      cmp("status", e.status, got.status);
      cmp("prog_counter", e.pc, got.pc);
      cmp("base_pointer", e.bp, got.bp);
      cmp("stack_pointer", e.sp, got.sp);
      cmp("data_pointer", e.dp, got.dp);
      cmp("out_valid", e.wvalid, got.wvalid);
      cmp("out_value", e.wvalue, got.wvalue);
      cmp("read_taken", e.taken, got.taken);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic [8:0] in_load_address;
  logic signed [31:0] in_load_value;
  logic signed [31:0] in_read_value;
  logic cfg_wr_en;
  logic [8:0] cfg_wr_data;
  logic out_strobe;
  logic [1:0] out_status;
  logic [8:0] out_prog_counter, out_base_pointer;
  logic [9:0] out_stack_pointer;
  logic signed [9:0] out_data_pointer;
  logic out_out_valid, out_read_taken;
  logic signed [31:0] out_out_value;

  pl0_scoreboard sb = new();
  int gap_pct;
  int items_sent;
  int programs;
  int code [$];

  pl0_stack_machine_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_load_address(in_load_address),
    .in_load_value(in_load_value), .in_read_value(in_read_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_prog_counter(out_prog_counter), .out_base_pointer(out_base_pointer),
    .out_stack_pointer(out_stack_pointer), .out_data_pointer(out_data_pointer),
    .out_out_valid(out_out_valid), .out_out_value(out_out_value),
    .out_read_taken(out_read_taken)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    vm_view_t got;
    if (rst_n && out_strobe) begin
      got.status = out_status;
      got.pc = out_prog_counter;
      got.bp = out_base_pointer;
      got.sp = out_stack_pointer;
      got.dp = out_data_pointer;
      got.wvalid = out_out_valid;
      got.wvalue = out_out_value;
      got.taken = out_read_taken;
      sb.check_result(got);
    end
  end

  // hold start high until the core takes the item
  task automatic send_item(bit [1:0] mode, bit [8:0] addr, int lval, int rval);
    start <= 1'b1;
    in_mode <= mode;
    in_load_address <= addr;
    in_load_value <= lval;
    in_read_value <= rval;
    do @(posedge clk); while (busy);
    sb.note_item(mode, addr, lval, rval);
    items_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_views.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_plen(bit [8:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.plen = v;
  endtask

  task automatic load_code();
    foreach (code[i]) send_item(MODE_LOAD, 9'(i), code[i], $urandom);
  endtask

  task automatic run_steps(int n);
    for (int k = 0; k < n && sb.status == ST_RUN; k++)
      send_item(MODE_STEP, 9'($urandom), $urandom, $urandom);
  endtask

  function automatic int rand_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    if (r < 12) return 0;
    return $urandom_range(0, 25) - 5;
  endfunction

  // mostly well-formed code with targets inside the program
  function automatic void gen_program(int n);
    int r, op, lv, m;
    code.delete();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      lv = ($urandom_range(0, 99) < 2) ? 600 : $urandom_range(0, 2);
      m = 3 * $urandom_range(0, n - 1);
      if ($urandom_range(0, 99) < 3) m = $urandom_range(0, 600);
      if (r < 2) begin
        op = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(10, 15);
      end else if (r < 22) begin
        op = OP_LIT; m = rand_operand();
      end else if (r < 47) begin
        op = OP_OPR;
        m = ($urandom_range(0, 99) < 3) ? $urandom_range(14, 20) : $urandom_range(0, 13);
      end else if (r < 57) begin
        op = OP_LOD; m = $urandom_range(0, 5);
      end else if (r < 67) begin
        op = OP_STO; m = $urandom_range(0, 5);
      end else if (r < 72) begin
        op = OP_CAL;
      end else if (r < 77) begin
        op = OP_INC; m = $urandom_range(0, 3);
      end else if (r < 81) begin
        op = OP_JMP;
      end else if (r < 87) begin
        op = OP_JPC;
      end else begin
        op = OP_SYS; m = $urandom_range(0, 4);
      end
      code.push_back(op);
      code.push_back(lv);
      code.push_back(m);
    end
    if ($urandom_range(0, 1) != 0) begin
      code.push_back(OP_SYS); code.push_back(0); code.push_back(SYS_HALT);
    end
  endfunction

  initial begin
    #20_000_000;
    $display("pl0_stack_machine_core: mismatch");
    $finish;
  end

  initial begin
    int r, plen;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_LOAD;
    in_load_address <= '0;
    in_load_value <= '0;
    in_read_value <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    gap_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // wait out the memory clearing sweep
    do @(posedge clk); while (busy);

    // directed: odd modes, faults from cleared memory, load extremes
    send_item(MODE_NONE, 9'h1ff, 32'h7fffffff, 32'h80000000);
    send_item(MODE_STEP, 0, 0, 0);
    send_item(MODE_STEP, 0, 0, 0);
    send_item(MODE_LOAD, 9'h1ff, 32'h80000000, 0);
    send_item(MODE_LOAD, 9'h1fe, 32'h7fffffff, 32'hffffffff);
    drain();
    write_plen(18);
    // most negative / -1, write it, then modulo by zero
    code = '{OP_LIT, 0, 32'h80000000, OP_LIT, 0, -1, OP_OPR, 0, OPR_DIV,
             OP_SYS, 0, SYS_WRITE, OP_LIT, 0, 0, OP_OPR, 0, OPR_MOD};
    load_code();
    send_item(MODE_START, 0, 0, 0);
    run_steps(8);

    while (items_sent < 1950) begin
      drain();
      gen_program($urandom_range(3, 14));
      r = $urandom_range(0, 99);
      if (programs == 0 || r < 5) plen = 511;
      else if (programs == 1 || r < 10) plen = 0;
      else if (r < 20) plen = $urandom_range(0, 511);
      else plen = code.size();
      case (programs % 3)
        0: gap_pct = 0;
        1: gap_pct = 54;
        default: gap_pct = 9;
      endcase
      write_plen(9'(plen));
      load_code();
      for (int rep = 0; rep < 2; rep++) begin
        send_item(MODE_START, 9'($urandom), $urandom, $urandom);
        run_steps(40);
      end
      // extra step items, stray loads and the unused mode
      if ($urandom_range(0, 3) == 0)
        send_item(MODE_STEP, 9'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 3) == 0)
        send_item(MODE_NONE, 9'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 3) == 0)
        send_item(MODE_LOAD, 9'($urandom_range(0, 511)), $urandom, $urandom);
      programs++;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("ran %0d programs, %0d items, %0d results checked", programs, items_sent,
             sb.checked);
    $display("saw %0d writes, %0d normal halts, %0d error halts", sb.writes, sb.halts,
             sb.faults);
    if (sb.errors == 0 && sb.expected_views.size() == 0)
      $display("pl0_stack_machine_core: match");
    else
      $display("pl0_stack_machine_core: mismatch");
    $finish;
  end

endmodule
